/* rtl/ipc_pkg.sv */
// Shared types, codes and helpers for the IP address text classifier.
package ipc_pkg;

  // Verdict codes on the result channel.
  localparam logic [1:0] VERDICT_NEITHER = 2'd0;
  localparam logic [1:0] VERDICT_IPV4    = 2'd1;
  localparam logic [1:0] VERDICT_IPV6    = 2'd2;

  // Character codes used by the classifier.
  localparam logic [7:0] CHAR_DOT   = 8'd46;
  localparam logic [7:0] CHAR_COLON = 8'd58;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;
  localparam logic [7:0] CHAR_LC_A  = 8'd97;
  localparam logic [7:0] CHAR_LC_F  = 8'd102;
  localparam logic [7:0] CHAR_UC_A  = 8'd65;
  localparam logic [7:0] CHAR_UC_F  = 8'd70;

  // Group limits.
  localparam int unsigned V4_MAX_VALUE = 255;
  localparam int unsigned V4_MAX_DIGS  = 3;
  localparam int unsigned V4_LAST_DOT  = 3;
  localparam int unsigned V6_MAX_DIGS  = 4;
  localparam int unsigned V6_LAST_COL  = 7;

  // Token queue between front and back; depth must be a power of two.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    TOK_DOT,
    TOK_COLON,
    TOK_DEC,
    TOK_HEX,
    TOK_OTHER
  } ipc_kind_e;

  typedef struct packed {
    ipc_kind_e  kind;
    logic [3:0] digit;
    logic       last;
  } ipc_token_t;

  function automatic ipc_token_t classify(input logic [7:0] c, input logic last);
    ipc_token_t t;
    t.last  = last;
    t.digit = 4'(c - CHAR_ZERO);
    if (c == CHAR_DOT) begin
      t.kind = TOK_DOT;
    end else if (c == CHAR_COLON) begin
      t.kind = TOK_COLON;
    end else if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
      t.kind = TOK_DEC;
    end else if (c inside {[CHAR_LC_A:CHAR_LC_F], [CHAR_UC_A:CHAR_UC_F]}) begin
      t.kind = TOK_HEX;
    end else begin
      t.kind = TOK_OTHER;
    end
    return t;
  endfunction

endpackage

/* rtl/ipc_if.sv */
// Valid/ready channel interfaces for characters in and verdicts out.
interface ipc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

interface ipc_verdict_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink (input valid, input verdict, output ready);
endinterface

/* rtl/ip_address_text_classifier_core.sv */
// IP address text classifier: top level tying front, token queue and checker together.
// Throughput: one character per cycle, sustained, when the result side keeps up.
// A last character's verdict is valid once its token has passed the front register, a queue slot
//   and the verdict register (the first loaded at the edge that takes the request).
// The rate is set by the rule update in the back stage.
// Reset (rst_ni low, asynchronous) empties the queue and rearms both rule checkers.
module ip_address_text_classifier_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  ipc_char_if.sink      in_i,
  ipc_verdict_if.source out_o
);

  // front -> queue
  logic                push_valid;
  logic                push_ready;
  ipc_pkg::ipc_token_t push_token;

  // queue -> back
  logic                pop_valid;
  logic                pop_ready;
  ipc_pkg::ipc_token_t pop_token;

  // Front classifies each character into a token (dot, colon, decimal digit,
  // hex letter or other) and holds it in a register.
  ipc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_token_o (push_token)
  );

  // Short FIFO lets the front keep taking requests while the verdict
  // register waits on the result side.
  ipc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_token_i (push_token),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_token_o  (pop_token)
  );

  // Back runs both rule sets side by side; on the last token it loads the
  // verdict register and clears its state for the next text.
  ipc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_token_i (pop_token),
    .out_o       (out_o)
  );

endmodule

/* rtl/ipc_front.sv */
// Front stage: accepts characters and registers their class as a token.
module ipc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  ipc_char_if.sink           in_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output ipc_pkg::ipc_token_t push_token_o
);

  logic                tok_valid_q, tok_valid_d;
  ipc_pkg::ipc_token_t tok_q, tok_d;
  logic                accept;

  assign in_i.ready = !tok_valid_q || push_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    tok_valid_d = tok_valid_q;
    tok_d       = tok_q;
    if (accept) begin
      tok_valid_d = 1'b1;
      tok_d       = ipc_pkg::classify(in_i.character, in_i.last);
    end else if (push_ready_i) begin
      tok_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign push_valid_o = tok_valid_q;
  assign push_token_o = tok_q;

endmodule

/* rtl/ipc_queue.sv */
// Short token FIFO decoupling the front stage from the checker.
module ipc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  ipc_pkg::ipc_token_t push_token_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output ipc_pkg::ipc_token_t pop_token_o
);

  ipc_pkg::ipc_token_t                    mem_q [ipc_pkg::QUEUE_DEPTH];
  logic [ipc_pkg::QUEUE_PTR_W-1:0]        wr_ptr_q, rd_ptr_q;
  logic [ipc_pkg::QUEUE_CNT_W-1:0]        count_q;
  logic                                   push, pop;

  assign push_ready_o = count_q != ipc_pkg::QUEUE_CNT_W'(ipc_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_token_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_token_i;
  end

endmodule

/* rtl/ipc_back.sv */
// Back stage: runs the IPv4 and IPv6 rule checks and issues the verdict.
module ipc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  ipc_pkg::ipc_token_t pop_token_i,
  ipc_verdict_if.source       out_o
);

  logic       v4_ok_q, v4_ok_d;
  logic [2:0] v4_groups_q, v4_groups_d;
  logic [8:0] v4_value_q, v4_value_d;
  logic [1:0] v4_digits_q, v4_digits_d;
  logic       v4_lz_q, v4_lz_d;
  logic       v6_ok_q, v6_ok_d;
  logic [3:0] v6_groups_q, v6_groups_d;
  logic [2:0] v6_digits_q, v6_digits_d;
  logic       colon_q, colon_d;
  logic       dot_q, dot_d;
  logic       out_valid_q, out_valid_d;
  logic [1:0] verdict_q, verdict_d;

  logic        fire;
  logic        v4_good, v6_good, v4_good_n, v6_good_n;
  logic [11:0] prod;
  logic        n_v4_ok, n_v4_lz, n_v6_ok, n_colon, n_dot;
  logic [2:0]  n_v4_groups;
  logic [8:0]  n_v4_value;
  logic [1:0]  n_v4_digits;
  logic [3:0]  n_v6_groups;
  logic [2:0]  n_v6_digits;
  logic [1:0]  verdict;

  // A token without last never produces a result, so it never waits.
  assign pop_ready_o = !pop_token_i.last || !out_valid_q || out_o.ready;
  assign fire        = pop_valid_i && pop_ready_o;

  assign v4_good = (v4_digits_q != 2'd0) && (v4_value_q <= 9'(ipc_pkg::V4_MAX_VALUE));
  assign v6_good = (v6_digits_q >= 3'd1) && (v6_digits_q <= 3'(ipc_pkg::V6_MAX_DIGS));
  assign prod    = {v4_value_q, 3'b000} + {2'b00, v4_value_q, 1'b0}
                 + {8'd0, pop_token_i.digit};

  always_comb begin
    n_v4_ok     = v4_ok_q;
    n_v4_groups = v4_groups_q;
    n_v4_value  = v4_value_q;
    n_v4_digits = v4_digits_q;
    n_v4_lz     = v4_lz_q;
    n_v6_ok     = v6_ok_q;
    n_v6_groups = v6_groups_q;
    n_v6_digits = v6_digits_q;
    n_colon     = colon_q;
    n_dot       = dot_q;

    // IPv4 view
    case (pop_token_i.kind)
      ipc_pkg::TOK_DOT: begin
        n_dot = 1'b1;
        if (!v4_good || v4_groups_q >= 3'(ipc_pkg::V4_LAST_DOT)) n_v4_ok = 1'b0;
        if (v4_groups_q < 3'd4) n_v4_groups = v4_groups_q + 3'd1;
        n_v4_value  = '0;
        n_v4_digits = '0;
        n_v4_lz     = 1'b0;
      end
      ipc_pkg::TOK_DEC: begin
        if (v4_digits_q == 2'd0) begin
          n_v4_lz = pop_token_i.digit == 4'd0;
        end else if (v4_lz_q) begin
          n_v4_ok = 1'b0;
        end
        if (v4_digits_q >= 2'(ipc_pkg::V4_MAX_DIGS)) begin
          n_v4_ok = 1'b0;
        end else begin
          n_v4_digits = v4_digits_q + 2'd1;
        end
        // saturate overlong values at 256
        if (prod > 12'(ipc_pkg::V4_MAX_VALUE)) begin
          n_v4_value = 9'(ipc_pkg::V4_MAX_VALUE + 1);
          n_v4_ok    = 1'b0;
        end else begin
          n_v4_value = prod[8:0];
        end
      end
      default: n_v4_ok = 1'b0;
    endcase

    // IPv6 view
    case (pop_token_i.kind)
      ipc_pkg::TOK_COLON: begin
        n_colon = 1'b1;
        if (!v6_good || v6_groups_q >= 4'(ipc_pkg::V6_LAST_COL)) n_v6_ok = 1'b0;
        if (v6_groups_q < 4'd8) n_v6_groups = v6_groups_q + 4'd1;
        n_v6_digits = '0;
      end
      ipc_pkg::TOK_DEC, ipc_pkg::TOK_HEX: begin
        if (v6_digits_q >= 3'(ipc_pkg::V6_MAX_DIGS)) n_v6_ok = 1'b0;
        if (v6_digits_q < 3'd5) n_v6_digits = v6_digits_q + 3'd1;
      end
      default: n_v6_ok = 1'b0;
    endcase
  end

  assign v4_good_n = (n_v4_digits != 2'd0) && (n_v4_value <= 9'(ipc_pkg::V4_MAX_VALUE));
  assign v6_good_n = (n_v6_digits >= 3'd1) && (n_v6_digits <= 3'(ipc_pkg::V6_MAX_DIGS));

  always_comb begin
    verdict = ipc_pkg::VERDICT_NEITHER;
    if (n_colon) begin
      if (n_v6_ok && v6_good_n && n_v6_groups == 4'(ipc_pkg::V6_LAST_COL))
        verdict = ipc_pkg::VERDICT_IPV6;
    end else if (n_dot) begin
      if (n_v4_ok && v4_good_n && n_v4_groups == 3'(ipc_pkg::V4_LAST_DOT))
        verdict = ipc_pkg::VERDICT_IPV4;
    end
  end

  always_comb begin
    v4_ok_d     = v4_ok_q;
    v4_groups_d = v4_groups_q;
    v4_value_d  = v4_value_q;
    v4_digits_d = v4_digits_q;
    v4_lz_d     = v4_lz_q;
    v6_ok_d     = v6_ok_q;
    v6_groups_d = v6_groups_q;
    v6_digits_d = v6_digits_q;
    colon_d     = colon_q;
    dot_d       = dot_q;
    out_valid_d = out_valid_q && !out_o.ready;
    verdict_d   = verdict_q;
    if (fire) begin
      if (pop_token_i.last) begin
        // text done: report and rearm for the next one
        out_valid_d = 1'b1;
        verdict_d   = verdict;
        v4_ok_d     = 1'b1;
        v4_groups_d = '0;
        v4_value_d  = '0;
        v4_digits_d = '0;
        v4_lz_d     = 1'b0;
        v6_ok_d     = 1'b1;
        v6_groups_d = '0;
        v6_digits_d = '0;
        colon_d     = 1'b0;
        dot_d       = 1'b0;
      end else begin
        v4_ok_d     = n_v4_ok;
        v4_groups_d = n_v4_groups;
        v4_value_d  = n_v4_value;
        v4_digits_d = n_v4_digits;
        v4_lz_d     = n_v4_lz;
        v6_ok_d     = n_v6_ok;
        v6_groups_d = n_v6_groups;
        v6_digits_d = n_v6_digits;
        colon_d     = n_colon;
        dot_d       = n_dot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_ok_q     <= 1'b1;
      v4_groups_q <= '0;
      v4_value_q  <= '0;
      v4_digits_q <= '0;
      v4_lz_q     <= 1'b0;
      v6_ok_q     <= 1'b1;
      v6_groups_q <= '0;
      v6_digits_q <= '0;
      colon_q     <= 1'b0;
      dot_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v4_ok_q     <= v4_ok_d;
      v4_groups_q <= v4_groups_d;
      v4_value_q  <= v4_value_d;
      v4_digits_q <= v4_digits_d;
      v4_lz_q     <= v4_lz_d;
      v6_ok_q     <= v6_ok_d;
      v6_groups_q <= v6_groups_d;
      v6_digits_q <= v6_digits_d;
      colon_q     <= colon_d;
      dot_q       <= dot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.verdict = verdict_q;

endmodule

/* tb/ipc_verdict_checker.sv */
// Watches both channels, predicts each verdict and compares it with the block's output.
`timescale 1ns / 1ps

module ipc_verdict_checker (
  input  logic   clk_i,
  input  logic   rst_ni,
  ipc_char_if    chars_i,
  ipc_verdict_if verdicts_i,
  output int     mismatches_o,
  output int     pending_o
);

  // Saturation points of the scan counters.
  localparam int unsigned V4_GROUP_SAT = 4;
  localparam int unsigned V4_VALUE_SAT = 256;
  localparam int unsigned V6_GROUP_SAT = 8;
  localparam int unsigned V6_DIGIT_SAT = 5;
  localparam int          PRINT_CAP    = 100;

  typedef struct packed {
    logic       v4_ok;
    logic [2:0] v4_groups;
    logic [8:0] v4_value;
    logic [1:0] v4_digits;
    logic       v4_lead_zero;
    logic       v6_ok;
    logic [3:0] v6_groups;
    logic [2:0] v6_digits;
    logic       colon_seen;
    logic       dot_seen;
  } addr_scan_t;

  addr_scan_t scan;
  logic [1:0] verdicts_due[$];
  logic [1:0] want;
  int         fails = 0;

  function automatic addr_scan_t scan_idle();
    addr_scan_t s;
    s = '0;
    s.v4_ok = 1'b1;
    s.v6_ok = 1'b1;
    return s;
  endfunction

  function automatic logic v4_group_good(addr_scan_t s);
    return s.v4_digits != 0 && s.v4_value <= ipc_pkg::V4_MAX_VALUE;
  endfunction

  function automatic logic v6_group_good(addr_scan_t s);
    return s.v6_digits >= 1 && s.v6_digits <= ipc_pkg::V6_MAX_DIGS;
  endfunction

  // Both views take every character.
  function automatic addr_scan_t scan_char(addr_scan_t s, logic [7:0] c);
    addr_scan_t  n;
    int unsigned acc;
    logic        is_dec;
    logic        is_hex;
    n      = s;
    is_dec = (c >= ipc_pkg::CHAR_ZERO && c <= ipc_pkg::CHAR_NINE);
    is_hex = is_dec || (c >= ipc_pkg::CHAR_LC_A && c <= ipc_pkg::CHAR_LC_F)
                    || (c >= ipc_pkg::CHAR_UC_A && c <= ipc_pkg::CHAR_UC_F);

    if (c == ipc_pkg::CHAR_DOT) begin
      n.dot_seen = 1'b1;
      if (!v4_group_good(s) || s.v4_groups >= ipc_pkg::V4_LAST_DOT) n.v4_ok = 1'b0;
      if (s.v4_groups < V4_GROUP_SAT) n.v4_groups = s.v4_groups + 3'd1;
      n.v4_value     = '0;
      n.v4_digits    = '0;
      n.v4_lead_zero = 1'b0;
    end else if (is_dec) begin
      if (s.v4_digits == 0) begin
        n.v4_lead_zero = (c == ipc_pkg::CHAR_ZERO);
      end else if (s.v4_lead_zero) begin
        n.v4_ok = 1'b0;
      end
      if (s.v4_digits >= ipc_pkg::V4_MAX_DIGS) n.v4_ok = 1'b0;
      else n.v4_digits = s.v4_digits + 2'd1;
      acc = s.v4_value * 10 + (c - ipc_pkg::CHAR_ZERO);
      if (acc > ipc_pkg::V4_MAX_VALUE) begin
        acc     = V4_VALUE_SAT;
        n.v4_ok = 1'b0;
      end
      n.v4_value = 9'(acc);
    end else begin
      n.v4_ok = 1'b0;
    end

    if (c == ipc_pkg::CHAR_COLON) begin
      n.colon_seen = 1'b1;
      if (!v6_group_good(s) || s.v6_groups >= ipc_pkg::V6_LAST_COL) n.v6_ok = 1'b0;
      if (s.v6_groups < V6_GROUP_SAT) n.v6_groups = s.v6_groups + 4'd1;
      n.v6_digits = '0;
    end else if (is_hex) begin
      if (s.v6_digits >= ipc_pkg::V6_MAX_DIGS) n.v6_ok = 1'b0;
      if (s.v6_digits < V6_DIGIT_SAT) n.v6_digits = s.v6_digits + 3'd1;
    end else begin
      n.v6_ok = 1'b0;
    end
    return n;
  endfunction

  // Any colon makes it an IPv6 question, else any dot an IPv4 one.
  function automatic logic [1:0] final_verdict(addr_scan_t s);
    if (s.colon_seen) begin
      if (s.v6_ok && v6_group_good(s) && s.v6_groups == ipc_pkg::V6_LAST_COL)
        return ipc_pkg::VERDICT_IPV6;
    end else if (s.dot_seen) begin
      if (s.v4_ok && v4_group_good(s) && s.v4_groups == ipc_pkg::V4_LAST_DOT)
        return ipc_pkg::VERDICT_IPV4;
    end
    return ipc_pkg::VERDICT_NEITHER;
  endfunction

  task automatic report_mismatch(input string what);
    if (fails < PRINT_CAP) $display("[%0t] verdict check: %s", $time, what);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan = scan_idle();
      verdicts_due.delete();
      pending_o <= 0;
    end else begin
      if (chars_i.valid && chars_i.ready) begin
        scan = scan_char(scan, chars_i.character);
        if (chars_i.last) begin
          verdicts_due.push_back(final_verdict(scan));
          scan = scan_idle();
        end
      end
      if (verdicts_i.valid && verdicts_i.ready) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch($sformatf("unexpected verdict %0d", verdicts_i.verdict));
        end else begin
          want = verdicts_due.pop_front();
          if (verdicts_i.verdict !== want) begin
            report_mismatch($sformatf("verdict %0d, predicted %0d",
                                      verdicts_i.verdict, want));
          end
        end
      end
      pending_o    <= verdicts_due.size();
      mismatches_o <= fails;
    end
  end

endmodule

/* tb/ip_address_text_classifier_core_tb.sv */
// Top of the classifier testbench: clock, reset, address text stimulus and the verdict.
`timescale 1ns / 1ps

module ip_address_text_classifier_core_tb;

  // Run shape. Item counts are characters, not texts.
  localparam int ITEMS_TARGET = 1550;
  localparam int PHASE1_AT    = 520;   // sender/receiver idle rates swap here
  localparam int PHASE2_AT    = 1040;  // no idling from here on
  localparam int HOLD_AT      = 1100;  // receiver starts its long hold-off here
  localparam int HOLD_CYCLES  = 250;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;

  localparam string HEX_CHARS   = "0123456789abcdefABCDEF";
  localparam string NOISE_CHARS = "0123456789abcdefABCDEFgxz.:/ ";

  // Ways a single group can be broken.
  typedef enum int {
    FAULT_LEAD_ZERO,
    FAULT_BIG_VALUE,
    FAULT_LONG,
    FAULT_EMPTY,
    FAULT_STRAY
  } group_fault_e;

  // One-character edits applied to a well-formed text.
  typedef enum int {
    EDIT_REPLACE,
    EDIT_DELETE,
    EDIT_INSERT
  } text_edit_e;

  logic clk_i;
  logic rst_ni;

  ipc_char_if    chr_if ();
  ipc_verdict_if vrd_if ();

  int mismatches;
  int pending;
  int items_sent = 0;
  int cycles     = 0;

  logic [7:0] text_buf[$];

  ip_address_text_classifier_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (chr_if),
    .out_o  (vrd_if)
  );

  ipc_verdict_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .chars_i      (chr_if),
    .verdicts_i   (vrd_if),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Idle rates by phase: sender 37/45/0, receiver 45/37/0 percent.
  function automatic int send_idle_pct();
    if (items_sent < PHASE1_AT) return 37;
    if (items_sent < PHASE2_AT) return 45;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (items_sent < PHASE1_AT) return 45;
    if (items_sent < PHASE2_AT) return 37;
    return 0;
  endfunction

  // Half the time any byte at all, so every bit of the character toggles.
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(1)) return 8'($urandom_range(255));
    return NOISE_CHARS[$urandom_range(NOISE_CHARS.len() - 1)];
  endfunction

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic push_hex(input int unsigned n);
    repeat (n) text_buf.push_back(HEX_CHARS[$urandom_range(HEX_CHARS.len() - 1)]);
  endtask

  task automatic push_v4_group(input bit faulty);
    int unsigned v;
    if (!faulty) begin
      // lean on the range ends: 0 and 255
      if ($urandom_range(3) == 0) v = $urandom_range(1) ? ipc_pkg::V4_MAX_VALUE : 0;
      else v = $urandom_range(ipc_pkg::V4_MAX_VALUE);
      push_str($sformatf("%0d", v));
    end else begin
      case (group_fault_e'($urandom_range(FAULT_STRAY)))
        FAULT_LEAD_ZERO: push_str($sformatf("0%0d", $urandom_range(99)));
        FAULT_BIG_VALUE: push_str($sformatf("%0d", $urandom_range(999, 256)));
        FAULT_LONG:      push_str($sformatf("%0d", $urandom_range(9999999, 1000)));
        FAULT_EMPTY:     ;
        default: begin
          push_str("1");
          text_buf.push_back(pick_byte());
        end
      endcase
    end
  endtask

  task automatic push_v6_group(input bit faulty);
    if (!faulty) begin
      push_hex($urandom_range(ipc_pkg::V6_MAX_DIGS, 1));
    end else begin
      case (group_fault_e'($urandom_range(FAULT_STRAY)))
        FAULT_LONG:  push_hex($urandom_range(7, 5));   // at or past the digit saturation
        FAULT_EMPTY: ;                                  // gives "::"
        FAULT_STRAY: begin
          push_hex(1);
          text_buf.push_back(pick_byte());
        end
        default: begin
          // a dot inside an otherwise fine hex group
          push_hex(2);
          text_buf.push_back(ipc_pkg::CHAR_DOT);
          push_hex(1);
        end
      endcase
    end
  endtask

  task automatic push_v4_text(input int unsigned groups, input int unsigned fault_pct);
    for (int g = 0; g < groups; g++) begin
      if (g != 0) text_buf.push_back(ipc_pkg::CHAR_DOT);
      push_v4_group($urandom_range(99) < fault_pct);
    end
  endtask

  task automatic push_v6_text(input int unsigned groups, input int unsigned fault_pct);
    for (int g = 0; g < groups; g++) begin
      if (g != 0) text_buf.push_back(ipc_pkg::CHAR_COLON);
      push_v6_group($urandom_range(99) < fault_pct);
    end
  endtask

  // Mostly well-formed or near-miss texts, so the deep rule paths get exercised;
  // the rest is single-character edits, noise and long separator runs.
  task automatic build_random_text();
    int unsigned r;
    int unsigned pos;
    logic [7:0]  sep;
    r = $urandom_range(99);
    if (r < 22) begin
      push_v4_text(4, 0);
    end else if (r < 44) begin
      push_v6_text(8, 0);
    end else if (r < 62) begin
      push_v4_text(($urandom_range(3) == 0) ? $urandom_range(6, 1) : 4, 25);
      if ($urandom_range(9) == 0) text_buf.push_back(ipc_pkg::CHAR_DOT);
    end else if (r < 80) begin
      push_v6_text(($urandom_range(3) == 0) ? $urandom_range(10, 6) : 8, 20);
      if ($urandom_range(9) == 0) text_buf.push_back(ipc_pkg::CHAR_COLON);
    end else if (r < 90) begin
      if ($urandom_range(1)) push_v4_text(4, 0);
      else push_v6_text(8, 0);
      pos = $urandom_range(text_buf.size() - 1);
      case (text_edit_e'($urandom_range(EDIT_INSERT)))
        EDIT_REPLACE: text_buf[pos] = pick_byte();
        EDIT_DELETE:  text_buf.delete(pos);
        default:      text_buf.insert(pos, pick_byte());
      endcase
    end else if (r < 96) begin
      repeat ($urandom_range(14, 1)) text_buf.push_back(pick_byte());
    end else begin
      // can drive the group counters into saturation
      sep = $urandom_range(1) ? ipc_pkg::CHAR_DOT : ipc_pkg::CHAR_COLON;
      repeat ($urandom_range(12, 5)) text_buf.push_back(sep);
      if ($urandom_range(1)) push_hex(1);
    end
  endtask

  // One request: optional idle gap, then hold valid until ready is seen at an edge.
  task automatic send_char(input logic [7:0] c, input logic fin);
    while ($urandom_range(99) < send_idle_pct()) begin
      chr_if.valid     <= 1'b0;
      chr_if.character <= 8'($urandom_range(255));
      chr_if.last      <= 1'($urandom_range(1));
      @(negedge clk_i);
    end
    chr_if.valid     <= 1'b1;
    chr_if.character <= c;
    chr_if.last      <= fin;
    do @(posedge clk_i); while (!chr_if.ready);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) send_char(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
  endtask

  // Sender and final verdict.
  initial begin
    chr_if.valid     = 1'b0;
    chr_if.character = '0;
    chr_if.last      = 1'b0;
    rst_ni           = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: a lone separator, no separator at all, the top byte value,
    // IPv4 with both value extremes, and a full IPv6 text with uppercase hex.
    push_str(".");
    send_text();
    push_str("a");
    send_text();
    text_buf.push_back(8'hFF);
    send_text();
    push_str("0.0.0.255");
    send_text();
    push_str("1:2:3:4:5:6:7:F");
    send_text();

    while (items_sent < ITEMS_TARGET) begin
      build_random_text();
      send_text();
    end
    chr_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Receiver: random ready by phase, plus one long hold-off once the run is in its
  // no-idle phase, so the block backs up and stalls its input while requests keep coming.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    vrd_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        vrd_if.ready <= 1'b0;
      end else begin
        vrd_if.ready <= ($urandom_range(99) >= recv_idle_pct());
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* files.f */
rtl/ipc_pkg.sv
rtl/ipc_if.sv
rtl/ipc_front.sv
rtl/ipc_queue.sv
rtl/ipc_back.sv
rtl/ip_address_text_classifier_core.sv
tb/ipc_verdict_checker.sv
tb/ip_address_text_classifier_core_tb.sv
